/* rtl/core/assert_macros.svh */
// assertion helpers for the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CHK_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

/* rtl/core/icf_pkg.sv */
`timescale 1ns / 1ps
package icf_pkg;
  localparam int KSIZE      = 3;
  localparam int KROWS      = 5;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 8;
  localparam int KROW_W     = 40;
  localparam int DIV_W      = 16;
  localparam int SIZE_W     = 11;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int KIDX_W     = $clog2(KSIZE);
  localparam int KROWIDX_W  = $clog2(KROWS);
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int SUM_W      = PROD_W + $clog2(KSIZE * KSIZE) + 1;
  localparam int QUO_W      = SUM_W - 1;
  localparam int DCNT_W     = $clog2(QUO_W + 1);
  localparam int LINE_W     = (KSIZE - 1) * PIX_W;
  localparam int PIX_MAX    = 255;
  localparam int ADDR_W     = 6;
  localparam int DATA_W     = 64;

  // register indexes, byte address is 8 * index
  localparam logic [2:0] REG_KROW0   = 3'd0;
  localparam logic [2:0] REG_KROW1   = 3'd1;
  localparam logic [2:0] REG_KROW2   = 3'd2;
  localparam logic [2:0] REG_KROW3   = 3'd3;
  localparam logic [2:0] REG_KROW4   = 3'd4;
  localparam logic [2:0] REG_DIVISOR = 3'd5;
  localparam logic [2:0] REG_WIDTH   = 3'd6;
  localparam logic [2:0] REG_HEIGHT  = 3'd7;
endpackage

/* rtl/core/image_convolution_filter.sv */
`timescale 1ns / 1ps
// 3x3 integer convolution over an 8-bit grayscale raster stream.
// input channel: in_pixel plus in_start_of_frame, one beat per pixel in
//   raster order; start_of_frame forces the position back to row 0, column 0.
// output channel: one beat per interior pixel, carrying its row, column,
//   clamped value and a frame_done flag on the last one; border pixels give none.
// configuration: apb-style port, 64-bit data, register i at byte 8*i;
//   write only while the block is idle.
// timing: one pixel at a time through one sequencer, in_stall high meanwhile:
//   accept, then line memory read/write back for every pixel; an interior
//   pixel adds multiply-accumulate over the nine taps (one tap per cycle), then
//   restoring division (load, then 21 quotient bits) for a positive sum or a
//   single clamp step for a clamped one, and a step to load the output
//   register, which waits while the output register is held.
// the 1024x16 line memory has a registered read; each pixel's read and
//   write back finish before the next pixel is taken.
// reset: synchronous active-low rst_n clears position, window, sequencer and
//   loads the identity kernel, divisor 1 and a 1024x1024 frame; the line
//   memory is not cleared, the first rows of a frame fill it.
// stall: a held output beat waits in the output register; the sequencer
//   takes the next pixel meanwhile and only waits if a new result is ready.
`include "assert_macros.svh"

module image_convolution_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [icf_pkg::PIX_W-1:0]         in_pixel,
  input  logic                              in_start_of_frame,
  // filtered result
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [icf_pkg::ROW_W-1:0]         out_row,
  output logic [icf_pkg::COL_W-1:0]         out_column,
  output logic [icf_pkg::PIX_W-1:0]         out_filtered_value,
  output logic                              out_frame_done,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [icf_pkg::ADDR_W-1:0]        paddr,
  input  logic [icf_pkg::DATA_W-1:0]        pwdata,
  output logic [icf_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [icf_pkg::KROW_W-1:0] krow_r [icf_pkg::KROWS];
  logic [icf_pkg::DIV_W-1:0]  divisor_r;
  logic [icf_pkg::SIZE_W-1:0] width_r;
  logic [icf_pkg::SIZE_W-1:0] height_r;

  // position of the next pixel
  logic [icf_pkg::ROW_W-1:0]  row_pos_r;
  logic [icf_pkg::COL_W-1:0]  col_pos_r;

  // pixel in flight
  logic [icf_pkg::PIX_W-1:0]  px_r;
  logic [icf_pkg::ROW_W-1:0]  cur_row_r;
  logic [icf_pkg::COL_W-1:0]  cur_col_r;
  logic                       cur_last_r;

  // window, [row][column], column KSIZE-1 is the newest
  logic [icf_pkg::PIX_W-1:0]  win_r [icf_pkg::KSIZE][icf_pkg::KSIZE];

  // line memory: low byte oldest line, high byte newer line
  logic [icf_pkg::LINE_W-1:0] line_mem [icf_pkg::MAX_WIDTH];
  logic [icf_pkg::LINE_W-1:0] line_rd_r;
  logic                       mem_we;
  logic [icf_pkg::LINE_W-1:0] mem_wdata;

  // arithmetic
  logic [icf_pkg::KIDX_W-1:0]        mac_i_r;
  logic [icf_pkg::KIDX_W-1:0]        mac_j_r;
  logic signed [icf_pkg::SUM_W-1:0]  acc_r;
  logic [icf_pkg::QUO_W-1:0]         num_r;
  logic [icf_pkg::DIV_W-1:0]         rem_r;
  logic [icf_pkg::DCNT_W-1:0]        dcnt_r;
  logic [icf_pkg::PIX_W-1:0]         res_r;

  // output register
  logic                       out_valid_r;
  logic [icf_pkg::ROW_W-1:0]  out_row_r;
  logic [icf_pkg::COL_W-1:0]  out_col_r;
  logic [icf_pkg::PIX_W-1:0]  out_val_r;
  logic                       out_done_r;

  logic                       in_acc;
  logic                       cfg_wr;
  logic [icf_pkg::SIZE_W-1:0] w_eff;
  logic [icf_pkg::SIZE_W-1:0] h_eff;
  logic                       pos_wrap;
  logic [icf_pkg::ROW_W-1:0]  r_now;
  logic [icf_pkg::COL_W-1:0]  c_now;
  logic [icf_pkg::SIZE_W-1:0] c_inc;
  logic [icf_pkg::SIZE_W-1:0] r_inc;
  logic [icf_pkg::PIX_W-1:0]  new_col [icf_pkg::KSIZE];
  logic                       interior;
  logic [icf_pkg::KROW_W-1:0] krow_sel;
  logic signed [icf_pkg::COEF_W-1:0] coef;
  logic signed [icf_pkg::PROD_W-1:0] prod;
  logic [icf_pkg::DIV_W-1:0]  d_eff;
  logic [icf_pkg::DIV_W:0]    trial;
  logic                       qbit;
  logic                       out_free;

  assign pready    = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign out_valid = out_valid_r;
  assign out_row            = out_row_r;
  assign out_column         = out_col_r;
  assign out_filtered_value = out_val_r;
  assign out_frame_done     = out_done_r;
  assign out_free  = !out_valid_r || !out_stall;

  // frame size in use, held to kernel..max
  always_comb begin
    if (width_r < icf_pkg::SIZE_W'(icf_pkg::KSIZE)) begin
      w_eff = icf_pkg::SIZE_W'(icf_pkg::KSIZE);
    end else if (width_r > icf_pkg::SIZE_W'(icf_pkg::MAX_WIDTH)) begin
      w_eff = icf_pkg::SIZE_W'(icf_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r < icf_pkg::SIZE_W'(icf_pkg::KSIZE)) begin
      h_eff = icf_pkg::SIZE_W'(icf_pkg::KSIZE);
    end else if (height_r > icf_pkg::SIZE_W'(icf_pkg::MAX_HEIGHT)) begin
      h_eff = icf_pkg::SIZE_W'(icf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // position of the accepted pixel: start of frame or a shrunk size wraps
  assign pos_wrap = in_start_of_frame
                 || ({1'b0, col_pos_r} >= w_eff)
                 || ({1'b0, row_pos_r} >= h_eff);
  assign r_now = pos_wrap ? '0 : row_pos_r;
  assign c_now = pos_wrap ? '0 : col_pos_r;
  assign c_inc = {1'b0, c_now} + 1'b1;
  assign r_inc = {1'b0, r_now} + 1'b1;

  // new window column: stored lines, oldest first, then the pixel
  always_comb begin
    for (int i = 0; i < icf_pkg::KSIZE - 1; i++) begin
      new_col[i] = line_rd_r[i*icf_pkg::PIX_W +: icf_pkg::PIX_W];
    end
    new_col[icf_pkg::KSIZE-1] = px_r;
    for (int i = 0; i < icf_pkg::KSIZE - 1; i++) begin
      mem_wdata[i*icf_pkg::PIX_W +: icf_pkg::PIX_W] = new_col[i+1];
    end
  end

  assign mem_we   = (state_r == ST_READ);
  assign interior = (cur_row_r >= icf_pkg::ROW_W'(icf_pkg::KSIZE - 1))
                 && (cur_col_r >= icf_pkg::COL_W'(icf_pkg::KSIZE - 1));

  // one tap per cycle
  assign krow_sel = krow_r[icf_pkg::KROWIDX_W'(mac_i_r)];
  assign coef     = $signed(krow_sel[mac_j_r*icf_pkg::COEF_W +: icf_pkg::COEF_W]);
  assign prod     = $signed({1'b0, win_r[mac_i_r][mac_j_r]}) * coef;

  // restoring division step on the sum's magnitude
  assign d_eff = (divisor_r == '0) ? icf_pkg::DIV_W'(1) : divisor_r;
  assign trial = {rem_r, num_r[icf_pkg::QUO_W-1]};
  assign qbit  = (trial >= {1'b0, d_eff});

  // line memory, one read and one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[cur_col_r] <= mem_wdata;
    end
    if (in_acc) begin
      line_rd_r <= line_mem[c_now];
    end
  end

  // payload registers of the pixel in flight
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r       <= in_pixel;
      cur_row_r  <= r_now;
      cur_col_r  <= c_now;
      cur_last_r <= ({1'b0, r_now} == h_eff - 1'b1) && ({1'b0, c_now} == w_eff - 1'b1);
    end
  end

  // sequencer, window, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      // identity kernel: coefficient 1 in the middle of row 1
      for (int i = 0; i < icf_pkg::KROWS; i++) begin
        krow_r[i] <= (i == 1) ? icf_pkg::KROW_W'(256) : '0;
      end
      divisor_r   <= icf_pkg::DIV_W'(1);
      width_r     <= icf_pkg::SIZE_W'(1024);
      height_r    <= icf_pkg::SIZE_W'(1024);
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      for (int i = 0; i < icf_pkg::KSIZE; i++) begin
        for (int j = 0; j < icf_pkg::KSIZE; j++) begin
          win_r[i][j] <= '0;
        end
      end
      mac_i_r     <= '0;
      mac_j_r     <= '0;
      acc_r       <= '0;
      num_r       <= '0;
      rem_r       <= '0;
      dcnt_r      <= '0;
      res_r       <= '0;
      out_valid_r <= 1'b0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_val_r   <= '0;
      out_done_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[icf_pkg::ADDR_W-1:3])
          icf_pkg::REG_KROW0,
          icf_pkg::REG_KROW1,
          icf_pkg::REG_KROW2,
          icf_pkg::REG_KROW3,
          icf_pkg::REG_KROW4:   krow_r[paddr[icf_pkg::ADDR_W-1:3]] <= pwdata[icf_pkg::KROW_W-1:0];
          icf_pkg::REG_DIVISOR: divisor_r <= pwdata[icf_pkg::DIV_W-1:0];
          icf_pkg::REG_WIDTH:   width_r   <= pwdata[icf_pkg::SIZE_W-1:0];
          icf_pkg::REG_HEIGHT:  height_r  <= pwdata[icf_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end

      // the output step handles a taken beat itself
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_READ;
            // advance position, wrap at row and frame end
            if (c_inc >= w_eff) begin
              col_pos_r <= '0;
              row_pos_r <= (r_inc >= h_eff) ? '0 : r_inc[icf_pkg::ROW_W-1:0];
            end else begin
              col_pos_r <= c_inc[icf_pkg::COL_W-1:0];
              row_pos_r <= r_now;
            end
          end
        end
        ST_READ: begin
          for (int i = 0; i < icf_pkg::KSIZE; i++) begin
            for (int j = 0; j < icf_pkg::KSIZE - 1; j++) begin
              win_r[i][j] <= win_r[i][j+1];
            end
            win_r[i][icf_pkg::KSIZE-1] <= new_col[i];
          end
          mac_i_r <= '0;
          mac_j_r <= '0;
          acc_r   <= '0;
          state_r <= interior ? ST_MAC : ST_IDLE;
        end
        ST_MAC: begin
          acc_r <= acc_r + icf_pkg::SUM_W'(prod);
          if (mac_j_r == icf_pkg::KIDX_W'(icf_pkg::KSIZE - 1)) begin
            mac_j_r <= '0;
            if (mac_i_r == icf_pkg::KIDX_W'(icf_pkg::KSIZE - 1)) begin
              state_r <= ST_DIV;
            end else begin
              mac_i_r <= mac_i_r + 1'b1;
            end
          end else begin
            mac_j_r <= mac_j_r + 1'b1;
          end
          num_r  <= '0;
          rem_r  <= '0;
          dcnt_r <= '0;
        end
        ST_DIV: begin
          if (dcnt_r == '0 && acc_r <= 0) begin
            // negative or zero sum clamps to zero
            res_r   <= '0;
            state_r <= ST_OUT;
          end else begin
            if (dcnt_r == '0) begin
              num_r <= acc_r[icf_pkg::QUO_W-1:0];
              rem_r <= '0;
            end else begin
              rem_r <= qbit ? icf_pkg::DIV_W'(trial - {1'b0, d_eff})
                            : trial[icf_pkg::DIV_W-1:0];
              num_r <= {num_r[icf_pkg::QUO_W-2:0], qbit};
            end
            if (dcnt_r == icf_pkg::DCNT_W'(icf_pkg::QUO_W)) begin
              state_r <= ST_OUT;
            end
            dcnt_r <= dcnt_r + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_row_r   <= cur_row_r - icf_pkg::ROW_W'(icf_pkg::KSIZE / 2);
            out_col_r   <= cur_col_r - icf_pkg::COL_W'(icf_pkg::KSIZE / 2);
            out_done_r  <= cur_last_r;
            // quotient of a positive sum is in num_r unless the sum was clamped
            if (acc_r <= 0) begin
              out_val_r <= res_r;
            end else if (|num_r[icf_pkg::QUO_W-1:icf_pkg::PIX_W]) begin
              out_val_r <= icf_pkg::PIX_W'(icf_pkg::PIX_MAX);
            end else begin
              out_val_r <= num_r[icf_pkg::PIX_W-1:0];
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    unique case (paddr[icf_pkg::ADDR_W-1:3])
      icf_pkg::REG_KROW0,
      icf_pkg::REG_KROW1,
      icf_pkg::REG_KROW2,
      icf_pkg::REG_KROW3,
      icf_pkg::REG_KROW4:   prdata = icf_pkg::DATA_W'(krow_r[paddr[icf_pkg::ADDR_W-1:3]]);
      icf_pkg::REG_DIVISOR: prdata = icf_pkg::DATA_W'(divisor_r);
      icf_pkg::REG_WIDTH:   prdata = icf_pkg::DATA_W'(width_r);
      icf_pkg::REG_HEIGHT:  prdata = icf_pkg::DATA_W'(height_r);
      default:              prdata = '0;
    endcase
  end

  // every accepted pixel goes straight to the memory read/write back step
  `CHK_NEXT(a_acc_read, clk, rst_n, in_acc, state_r == ST_READ)
  // an output beat is only ever loaded from the output step
  `CHK_NOW(a_out_src, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_OUT))
  // the tap counters stay inside the kernel while accumulating
  `CHK_NOW(a_mac_range, clk, rst_n, state_r == ST_MAC, (mac_i_r < icf_pkg::KIDX_W'(icf_pkg::KSIZE)) && (mac_j_r < icf_pkg::KIDX_W'(icf_pkg::KSIZE)))

endmodule
